[rtl/core/text_console_writer_core_defines.svh]
// Assertion macros for the text console core.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcw assertion failed");
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcw assertion failed");
`else
`define TCW_ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/tcw_pkg.sv]
// Shared types and constants of the text console core.
// No dependencies; imported by every module of the core except tcw_ram.
`default_nettype none

package tcw_pkg;

  localparam int TCW_COLUMNS     = 80;
  localparam int TCW_ROWS        = 25;
  localparam int TCW_QUEUE_DEPTH = 2;

  localparam int CURSOR_W = 11;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [15:0] BLANK_CELL   = 16'h0720;

  typedef enum logic [1:0] {
    OP_PUTC  = 2'd0,
    OP_PUTAT = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } tcw_op_t;

  // Work kinds after classification in the front end.
  typedef enum logic [2:0] {
    K_PUTC,
    K_NEWLINE,
    K_WRITE,
    K_SKIP,
    K_READ,
    K_READ_NONE,
    K_CLEAR
  } tcw_kind_t;

  typedef struct packed {
    tcw_kind_t   kind;
    logic [15:0] cell_word;  // attribute in high byte, character in low byte
  } tcw_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DRAIN,
    ST_BLANK
  } tcw_state_t;

endpackage

`default_nettype wire

[rtl/core/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcw_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [W-1:0]             wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/tcw_front.sv]
// Front end: takes input beats and classifies them into work commands.
// Depends on tcw_pkg.
`default_nettype none

module tcw_front
  import tcw_pkg::*;
#(
  parameter int COLUMNS = TCW_COLUMNS,
  parameter int ROWS    = TCW_ROWS,
  parameter int AW      = $clog2(TCW_COLUMNS * TCW_ROWS)
) (
  input  wire logic          in_tvalid,
  output      logic          in_tready,
  input  wire logic [31:0]   in_tdata,   // char_code, attribute, row, column
  input  wire logic [1:0]    in_tuser,   // op
  output      logic          push_valid,
  input  wire logic          push_ready,
  output      tcw_cmd_t      push_cmd,
  output      logic [AW-1:0] push_addr
);

  logic [7:0] ch;
  logic [7:0] attr;
  logic [4:0] row;
  logic [6:0] col;
  logic       on_screen;

  assign ch   = in_tdata[7:0];
  assign attr = in_tdata[15:8];
  assign row  = in_tdata[20:16];
  assign col  = in_tdata[27:21];

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  assign on_screen = (32'(row) < ROWS) && (32'(col) < COLUMNS);
  assign push_addr = AW'(32'(row) * COLUMNS + 32'(col));

  always_comb begin
    push_cmd.cell_word = {attr, ch};
    unique case (tcw_op_t'(in_tuser))
      OP_PUTC:  push_cmd.kind = (ch == NEWLINE_CODE) ? K_NEWLINE : K_PUTC;
      OP_PUTAT: push_cmd.kind = on_screen ? K_WRITE : K_SKIP;
      OP_READ:  push_cmd.kind = on_screen ? K_READ : K_READ_NONE;
      OP_CLEAR: push_cmd.kind = K_CLEAR;
      default:  push_cmd.kind = K_SKIP;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/tcw_fifo.sv]
// Small command queue between front end and back end.
// Depends on tcw_pkg for the default depth.
`default_nettype none

module tcw_fifo
  import tcw_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = TCW_QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output      logic         push_ready,
  input  wire logic [W-1:0] push_data,
  output      logic         pop_valid,
  input  wire logic         pop_ready,
  output      logic [W-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            push, pop;

  assign push_ready = (count_r != CNTW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tcw_back.sv]
// Back end: executes console commands against the screen RAM, runs the
// scroll copy and the blanking sweeps, and holds the result register.
// Depends on tcw_pkg, tcw_ram and the core defines header.
`default_nettype none
`include "text_console_writer_core_defines.svh"

module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLUMNS = TCW_COLUMNS,
  parameter int ROWS    = TCW_ROWS,
  parameter int AW      = $clog2(TCW_COLUMNS * TCW_ROWS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output      logic          q_ready,
  input  wire tcw_cmd_t      q_cmd,
  input  wire logic [AW-1:0] q_addr,
  output      logic          out_tvalid,
  input  wire logic          out_tready,
  output      logic [31:0]   out_tdata   // cell_char, cell_attribute, cursor
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int COLW  = $clog2(COLUMNS);

  tcw_state_t      state_r, state_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic            emit_r, emit_nxt;
  logic [CW-1:0]   cur_r, cur_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic            cp_pend_r;
  logic [AW-1:0]   cp_dst_r;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_char_r, out_attr_r;
  logic [CURSOR_W-1:0] out_cursor_r;

  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [15:0]     wr_data, rd_data;
  logic            load;
  logic [15:0]     ld_cell;
  logic [CW-1:0]   adv_cur;

  tcw_ram #(.W(16), .DEPTH(CELLS)) u_screen (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    emit_nxt  = emit_r;
    cur_nxt   = cur_r;
    col_nxt   = col_r;
    q_ready   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = ptr_r;
    wr_data   = BLANK_CELL;
    rd_en     = 1'b0;
    rd_addr   = q_addr;
    load      = 1'b0;
    ld_cell   = '0;
    adv_cur   = (q_cmd.kind == K_NEWLINE) ? cur_r + CW'(COLUMNS) - CW'(col_r)
                                          : cur_r + 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_ready = 1'b1;
          unique case (q_cmd.kind)
            K_PUTC, K_NEWLINE: begin
              if (q_cmd.kind == K_PUTC) begin
                wr_en   = 1'b1;
                wr_addr = AW'(cur_r);
                wr_data = q_cmd.cell_word;
              end
              if (adv_cur == CW'(CELLS)) begin
                cur_nxt   = CW'(CELLS - COLUMNS);
                col_nxt   = '0;
                ptr_nxt   = AW'(COLUMNS);
                state_nxt = ST_SCROLL;
              end else begin
                cur_nxt = adv_cur;
                if (q_cmd.kind == K_NEWLINE || col_r == COLW'(COLUMNS - 1)) begin
                  col_nxt = '0;
                end else begin
                  col_nxt = col_r + 1'b1;
                end
                load = 1'b1;
              end
            end
            K_WRITE: begin
              wr_en   = 1'b1;
              wr_addr = q_addr;
              wr_data = q_cmd.cell_word;
              load    = 1'b1;
            end
            K_READ: begin
              rd_en     = 1'b1;
              state_nxt = ST_READ;
            end
            K_CLEAR: begin
              cur_nxt   = '0;
              col_nxt   = '0;
              ptr_nxt   = '0;
              emit_nxt  = 1'b1;
              state_nxt = ST_BLANK;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load      = 1'b1;
        ld_cell   = rd_data;
        state_nxt = ST_IDLE;
      end
      ST_SCROLL: begin
        rd_en   = 1'b1;
        rd_addr = ptr_r;
        if (cp_pend_r) begin
          wr_en   = 1'b1;
          wr_addr = cp_dst_r;
          wr_data = rd_data;
        end
        if (ptr_r == AW'(CELLS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        wr_en     = 1'b1;
        wr_addr   = cp_dst_r;
        wr_data   = rd_data;
        ptr_nxt   = AW'(CELLS - COLUMNS);
        emit_nxt  = 1'b1;
        state_nxt = ST_BLANK;
      end
      ST_BLANK: begin
        wr_en = 1'b1;
        if (ptr_r == AW'(CELLS - 1)) begin
          load      = emit_r;
          emit_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BLANK;
      ptr_r       <= '0;
      emit_r      <= 1'b0;
      cur_r       <= '0;
      col_r       <= '0;
      cp_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      emit_r      <= emit_nxt;
      cur_r       <= cur_nxt;
      col_r       <= col_nxt;
      cp_pend_r   <= (state_r == ST_SCROLL);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_dst_r <= AW'(ptr_r - AW'(COLUMNS));
    if (load) begin
      out_char_r   <= ld_cell[7:0];
      out_attr_r   <= ld_cell[15:8];
      out_cursor_r <= CURSOR_W'(cur_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_cursor_r, out_attr_r, out_char_r};

  `TCW_ASSERT_HOLDS(a_cursor_on_screen, clk, rst_n, state_r == ST_IDLE, cur_r < CW'(CELLS))
  `TCW_ASSERT_HOLDS(a_pop_slot_free, clk, rst_n, q_ready, !out_valid_r)
  `TCW_ASSERT_HOLDS(a_copy_dst_low, clk, rst_n, cp_pend_r, cp_dst_r < AW'(CELLS - COLUMNS))
  `TCW_ASSERT_HOLDS(a_scroll_cursor, clk, rst_n, state_r == ST_DRAIN, cur_r == CW'(CELLS - COLUMNS) && col_r == '0)
  `TCW_ASSERT_NEXT(a_sweep_result, clk, rst_n, state_r == ST_BLANK && ptr_r == AW'(CELLS - 1) && emit_r, out_valid_r)

endmodule

`default_nettype wire

[rtl/core/text_console_writer_core.sv]
// Channel  Dir  Beat fields (tdata low bit up)                    tuser
// in_      in   char_code[7:0] attribute[15:8] row[20:16] col[27:21]  op[1:0]
// out_     out  cell_char[7:0] cell_attribute[15:8] cursor[26:16]  -
//
// From input beat to result beat, a beat passes through the command queue and
// the result register; an on-screen read also passes through ST_READ
// (registered screen RAM port).
// A scroll runs a row-copy pass of (ROWS-1)*COLUMNS reads plus one drain write,
// then bottom-row blanking, one cell per cycle through the single write port.
// Clear blanks all COLUMNS*ROWS cells through the same sweep.
// After reset the back end blanks all COLUMNS*ROWS cells of the RAM; beats are
// queued meanwhile up to QUEUE_DEPTH and then in_tready drops.
// Top level of the text console core; depends on tcw_pkg, tcw_front,
// tcw_fifo, tcw_back and tcw_ram.
`default_nettype none

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS     = TCW_COLUMNS,
  parameter int ROWS        = TCW_ROWS,
  parameter int QUEUE_DEPTH = TCW_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // char_code, attribute, row, column
  input  wire logic [1:0]  in_tuser,   // op
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata   // cell_char, cell_attribute, cursor
);

  localparam int AW = $clog2(COLUMNS * ROWS);
  localparam int QW = $bits(tcw_cmd_t) + AW;

  logic          push_valid, push_ready;
  tcw_cmd_t      push_cmd;
  logic [AW-1:0] push_addr;
  logic          pop_valid, pop_ready;
  logic [QW-1:0] pop_data;
  tcw_cmd_t      q_cmd;
  logic [AW-1:0] q_addr;

  tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS), .AW(AW)) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .push_addr  (push_addr)
  );

  tcw_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_addr, push_cmd}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign q_cmd  = tcw_cmd_t'(pop_data[$bits(tcw_cmd_t)-1:0]);
  assign q_addr = pop_data[QW-1:$bits(tcw_cmd_t)];

  tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .AW(AW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_cmd      (q_cmd),
    .q_addr     (q_addr),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[verif/text_console_writer_core_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer_core: directed, scroll, stall and random beats.
// Keeps its own screen and cursor predictor; depends on tcw_pkg and the core RTL.
module text_console_writer_core_test;
  import tcw_pkg::*;

  localparam int COLS        = TCW_COLUMNS;
  localparam int LINES       = TCW_ROWS;
  localparam int CELL_COUNT  = COLS * LINES;
  localparam int STALL_LIMIT = 25000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_GOAL = 480;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [10:0] cursor;
  } console_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  logic [15:0]     screen_cells [CELL_COUNT];
  int unsigned     model_cursor;
  console_result_t console_results_due[$];

  int mismatch_count = 0;
  int beats_sent     = 0;
  int results_seen   = 0;
  int quiet_cycles   = 0;
  int hold_cycles    = 0;
  bit no_idle        = 1'b0;

  text_console_writer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = BLANK_CELL;
    model_cursor = 0;
  endfunction

  function automatic console_result_t console_step(input tcw_op_t op, input logic [7:0] ch,
                                                   input logic [7:0] attr,
                                                   input logic [4:0] row,
                                                   input logic [6:0] col);
    console_result_t r;
    logic [15:0]     cell_word;
    logic            on_screen;
    int              where;
    r         = '0;
    cell_word = {attr, ch};
    on_screen = (int'(row) < LINES) && (int'(col) < COLS);
    where     = int'(row) * COLS + int'(col);
    case (op)
      OP_PUTC: begin
        if (ch == NEWLINE_CODE) begin
          model_cursor = (model_cursor / COLS + 1) * COLS;
        end else begin
          screen_cells[model_cursor] = cell_word;
          model_cursor++;
        end
        if (model_cursor >= CELL_COUNT) begin
          for (int i = 0; i < CELL_COUNT - COLS; i++) screen_cells[i] = screen_cells[i + COLS];
          for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++) screen_cells[i] = BLANK_CELL;
          model_cursor = CELL_COUNT - COLS;
        end
      end
      OP_PUTAT: begin
        if (on_screen) screen_cells[where] = cell_word;
      end
      OP_READ: begin
        if (on_screen) begin
          r.cell_char = screen_cells[where][7:0];
          r.cell_attr = screen_cells[where][15:8];
        end
      end
      default: begin
        blank_screen();
      end
    endcase
    r.cursor = model_cursor[10:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: result %0d %s got 0x%0h want 0x%0h", $time, results_seen, what, got, want);
    mismatch_count++;
  endtask

  // one input beat; valid stays high after the handshake until the next call
  task automatic send_beat(input tcw_op_t op, input logic [7:0] ch, input logic [7:0] attr,
                           input logic [4:0] row, input logic [6:0] col);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, col, row, attr, ch};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    console_results_due.push_back(console_step(op, ch, attr, row, col));
    beats_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (console_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_newline();
    send_beat(OP_PUTC, NEWLINE_CODE, 8'($urandom), 5'($urandom), 7'($urandom));
  endtask

  task automatic send_read(input int r, input int c);
    send_beat(OP_READ, 8'($urandom), 8'($urandom), 5'(r), 7'(c));
  endtask

  task automatic send_random_beat();
    int   pick;
    int   last;
    logic [4:0] row;
    logic [6:0] col;
    pick = $urandom_range(0, 99);
    row  = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, LINES - 1));
    col  = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, COLS - 1));
    if (pick < 45) begin
      send_beat(OP_PUTC, ($urandom_range(0, 5) == 0) ? NEWLINE_CODE : 8'($urandom),
                8'($urandom), 5'($urandom), 7'($urandom));
    end else if (pick < 65) begin
      send_beat(OP_PUTAT, 8'($urandom), 8'($urandom), row, col);
    end else if (pick < 97) begin
      // half the reads look at the cell just behind the cursor, when it is past cell 0
      if (model_cursor > 0 && $urandom_range(0, 1) == 0) begin
        last = int'(model_cursor) - 1;
        send_read(last / COLS, last % COLS);
      end else begin
        send_beat(OP_READ, 8'($urandom), 8'($urandom), row, col);
      end
    end else begin
      send_beat(OP_CLEAR, 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
    end
  endtask

  task automatic test_cell_ops();
    send_read(0, 0);
    send_read(LINES - 1, COLS - 1);
    send_beat(OP_PUTAT, 8'hFF, 8'hFF, 5'(LINES - 1), 7'(COLS - 1));
    send_read(LINES - 1, COLS - 1);
    send_beat(OP_PUTAT, 8'h41, 8'h1F, 5'(LINES), 7'd5);
    send_read(LINES, 5);
    send_beat(OP_PUTAT, 8'h42, 8'h2E, 5'd0, 7'(COLS));
    send_read(0, COLS);
    send_beat(OP_PUTAT, 8'h55, 8'hAA, 5'd31, 7'd127);
    send_read(31, 127);
    send_beat(OP_PUTAT, NEWLINE_CODE, 8'h1E, 5'd0, 7'd1);
    send_read(0, 1);
    send_beat(OP_PUTC, 8'h00, 8'h00, 5'd31, 7'd127);
    send_beat(OP_PUTC, 8'hFF, 8'h80, 5'd3, 7'd9);
    send_newline();
    send_beat(OP_PUTC, 8'h41, 8'h4F, 5'd0, 7'd0);
    send_read(0, 0);
    send_read(0, 1);
    send_read(1, 0);
    send_beat(OP_CLEAR, 8'hFF, 8'hFF, 5'd31, 7'd127);
    send_read(LINES - 1, COLS - 1);
    send_read(0, 0);
  endtask

  task automatic test_scroll();
    send_beat(OP_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0);
    repeat (LINES - 1) send_newline();
    send_beat(OP_PUTAT, 8'h31, 8'h17, 5'd1, 7'd7);
    send_beat(OP_PUTAT, 8'h32, 8'h27, 5'(LINES - 1), 7'd5);
    send_beat(OP_PUTC, 8'h5A, 8'h3C, 5'd0, 7'd0);
    send_newline();
    send_read(0, 7);
    send_read(LINES - 2, 5);
    send_read(LINES - 2, 0);
    send_read(LINES - 1, 0);
    // second newline in a row must scroll again
    send_newline();
    send_read(LINES - 3, 5);
    send_read(LINES - 2, 0);
    repeat (COLS) begin
      send_beat(OP_PUTC, 8'($urandom_range(11, 255)), 8'($urandom), 5'($urandom), 7'($urandom));
    end
    send_read(LINES - 2, 0);
    send_read(LINES - 2, COLS - 1);
    send_read(LINES - 1, 0);
  endtask

  task automatic test_backpressure();
    no_idle     = 1'b1;
    hold_cycles = 300;
    repeat (12) send_random_beat();
    wait_drained();
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    int segment;
    int n;
    segment = 0;
    while (beats_sent < RANDOM_GOAL) begin
      no_idle = (segment >= 4 && segment < 8);
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(20, 28);
          repeat (n) begin
            if ($urandom_range(0, 4) == 0) send_random_beat();
            else send_newline();
          end
        end
        2: begin
          n = $urandom_range(40, 90);
          repeat (n) begin
            send_beat(OP_PUTC, 8'($urandom_range(11, 255)), 8'($urandom),
                      5'($urandom), 7'($urandom));
          end
        end
        default: begin
          n = $urandom_range(8, 25);
          repeat (n) send_random_beat();
        end
      endcase
      if ($urandom_range(0, 7) == 0) wait_drained();
      segment++;
    end
    no_idle = 1'b0;
  endtask

  // receiver: random stalls, a counted hold-off when requested, or always ready while no_idle is set
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 15);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (console_results_due.size() == 0) begin
        report_mismatch("unexpected beat, tdata", int'(out_tdata), 0);
      end else begin
        console_result_t want;
        want = console_results_due.pop_front();
        if (out_tdata[7:0] !== want.cell_char)
          report_mismatch("cell_char", int'(out_tdata[7:0]), int'(want.cell_char));
        if (out_tdata[15:8] !== want.cell_attr)
          report_mismatch("cell_attribute", int'(out_tdata[15:8]), int'(want.cell_attr));
        if (out_tdata[26:16] !== want.cursor)
          report_mismatch("cursor", int'(out_tdata[26:16]), int'(want.cursor));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_PUTC;
    blank_screen();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_cell_ops();
    test_scroll();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (console_results_due.size() != 0)
      report_mismatch("results never arrived, count", 0, console_results_due.size());
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
